FILE: rtl/b64se_pkg.sv
// shared types, constants and character helpers for the base64 stream encoder
package b64se_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] REG_ALPHABET = 2'd0;
  localparam logic [1:0] REG_PAD      = 2'd1;

  localparam logic [1:0] PAD_EQ   = 2'd0;
  localparam logic [1:0] PAD_PCT  = 2'd1;
  localparam logic [1:0] PAD_NONE = 2'd2;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2b;
  localparam logic [7:0] CHAR_SLASH   = 8'h2f;
  localparam logic [7:0] CHAR_MINUS   = 8'h2d;
  localparam logic [7:0] CHAR_UNDER   = 8'h5f;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_THREE   = 8'h33;
  localparam logic [7:0] CHAR_LOWER_D = 8'h64;

  typedef struct packed {
    logic       alphabet;
    logic [1:0] pad;
  } cfg_t;

  // one group ready for encoding
  typedef struct packed {
    logic [23:0] triple;
    logic [2:0]  ndata;
    logic [1:0]  npad;
    logic        last;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_PAD
  } back_state_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] s, input logic alphabet);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = CHAR_UPPER_A + {2'b00, s};
    end else if (s < 6'd52) begin
      c = CHAR_LOWER_A + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = CHAR_ZERO + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = alphabet ? CHAR_MINUS : CHAR_PLUS;
    end else begin
      c = alphabet ? CHAR_UNDER : CHAR_SLASH;
    end
    return c;
  endfunction

  function automatic logic pad_active(input logic [1:0] pad);
    return (pad == PAD_EQ) || (pad == PAD_PCT);
  endfunction

endpackage

FILE: rtl/b64se_front.sv
// front end: gathers bytes into groups and issues encode jobs
module b64se_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               end_of_message,
  input  logic               q_full,
  output logic               q_push,
  output b64se_pkg::job_t    q_job
);

  logic [15:0] held;
  logic [15:0] held_next;
  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && (end_of_message || phase[1]);

  always_comb begin
    held_next  = held;
    phase_next = phase;
    q_job      = '0;
    q_job.last = end_of_message;
    if (phase == 2'd0) begin
      q_job.triple = {data_byte, 16'h0000};
      q_job.ndata  = 3'd2;
      q_job.npad   = 2'd2;
    end else if (phase == 2'd1) begin
      q_job.triple = {held[7:0], data_byte, 8'h00};
      q_job.ndata  = 3'd3;
      q_job.npad   = 2'd1;
    end else begin
      q_job.triple = {held, data_byte};
      q_job.ndata  = 3'd4;
      q_job.npad   = 2'd0;
    end
    if (accept) begin
      if (end_of_message || phase[1]) begin
        held_next  = 16'h0000;
        phase_next = 2'd0;
      end else begin
        held_next  = {held[7:0], data_byte};
        phase_next = phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 16'h0000;
      phase <= 2'd0;
    end else begin
      held  <= held_next;
      phase <= phase_next;
    end
  end

endmodule

FILE: rtl/b64se_queue.sv
// short job queue between front and back ends
module b64se_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64se_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output b64se_pkg::job_t head_job
);

  b64se_pkg::job_t                entries [b64se_pkg::QDEPTH];
  logic [b64se_pkg::QPTR_W-1:0]   wptr;
  logic [b64se_pkg::QPTR_W-1:0]   rptr;
  logic [b64se_pkg::QCNT_W-1:0]   count;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (count == b64se_pkg::QCNT_W'(b64se_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/b64se_back.sv
// back end: steps through data and padding characters of each job
module b64se_back (
  input  logic            clk,
  input  logic            rst,
  input  b64se_pkg::cfg_t cfg,
  input  logic            q_valid,
  input  b64se_pkg::job_t q_job,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_char,
  output logic            out_final
);

  b64se_pkg::back_state_t state;
  b64se_pkg::back_state_t state_next;
  b64se_pkg::job_t        cur;
  logic [1:0]             dpos;
  logic [1:0]             dpos_next;
  logic                   ppos;
  logic                   ppos_next;
  logic [1:0]             sub;
  logic [1:0]             sub_next;
  logic                   out_load;
  logic                   emit;
  logic [7:0]             emit_char;
  logic                   emit_final;
  logic [5:0]             sextet;
  logic                   last_data;
  logic                   pad_done;
  logic                   last_pad;
  logic                   pads_follow;

  assign out_load    = !out_valid || !out_stall;
  assign last_data   = ({1'b0, dpos} == (cur.ndata - 3'd1));
  assign pad_done    = (cfg.pad == b64se_pkg::PAD_EQ) || (sub == 2'd2);
  assign last_pad    = ({1'b0, ppos} == (cur.npad - 2'd1)) && pad_done;
  assign pads_follow = b64se_pkg::pad_active(cfg.pad) && (cur.npad != 2'd0);

  always_comb begin
    case (dpos)
      2'd0:    sextet = cur.triple[23:18];
      2'd1:    sextet = cur.triple[17:12];
      2'd2:    sextet = cur.triple[11:6];
      default: sextet = cur.triple[5:0];
    endcase
  end

  always_comb begin
    state_next = state;
    dpos_next  = dpos;
    ppos_next  = ppos;
    sub_next   = sub;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_char  = 8'h00;
    emit_final = 1'b0;
    unique case (state)
      b64se_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          dpos_next  = 2'd0;
          state_next = b64se_pkg::ST_DATA;
        end
      end
      b64se_pkg::ST_DATA: begin
        if (out_load) begin
          emit       = 1'b1;
          emit_char  = b64se_pkg::sextet_char(sextet, cfg.alphabet);
          emit_final = last_data && cur.last && !pads_follow;
          if (last_data) begin
            ppos_next  = 1'b0;
            sub_next   = 2'd0;
            state_next = pads_follow ? b64se_pkg::ST_PAD : b64se_pkg::ST_IDLE;
          end else begin
            dpos_next = dpos + 2'd1;
          end
        end
      end
      b64se_pkg::ST_PAD: begin
        if (out_load) begin
          emit       = 1'b1;
          emit_final = last_pad && cur.last;
          if (cfg.pad == b64se_pkg::PAD_EQ) begin
            emit_char = b64se_pkg::CHAR_EQUALS;
          end else begin
            case (sub)
              2'd0:    emit_char = b64se_pkg::CHAR_PERCENT;
              2'd1:    emit_char = b64se_pkg::CHAR_THREE;
              default: emit_char = b64se_pkg::CHAR_LOWER_D;
            endcase
          end
          if (pad_done) begin
            sub_next = 2'd0;
            if (last_pad) begin
              state_next = b64se_pkg::ST_IDLE;
            end else begin
              ppos_next = 1'b1;
            end
          end else begin
            sub_next = sub + 2'd1;
          end
        end
      end
      default: begin
        state_next = b64se_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b64se_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dpos      <= 2'd0;
      ppos      <= 1'b0;
      sub       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      dpos <= dpos_next;
      ppos <= ppos_next;
      sub  <= sub_next;
      if (out_load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    if (out_load && emit) begin
      out_char  <= emit_char;
      out_final <= emit_final;
    end
  end

  a_pad_only_when_padding: assert property (@(posedge clk) disable iff (rst)
    state == b64se_pkg::ST_PAD |-> b64se_pkg::pad_active(cfg.pad) && cur.npad != 2'd0)
    else $error("padding step without padding to send");

  a_pad_index_in_range: assert property (@(posedge clk) disable iff (rst)
    state == b64se_pkg::ST_PAD |-> {1'b0, ppos} < cur.npad)
    else $error("pad index past pad count");

  a_data_index_in_range: assert property (@(posedge clk) disable iff (rst)
    state == b64se_pkg::ST_DATA |-> {1'b0, dpos} < cur.ndata && cur.ndata >= 3'd2)
    else $error("data index past data count");

  a_final_ends_job: assert property (@(posedge clk) disable iff (rst)
    out_load && emit && emit_final |=> state == b64se_pkg::ST_IDLE)
    else $error("final character sent with job still running");

endmodule

FILE: rtl/base64_stream_encoder_unit.sv
// top level of the base64 stream encoder
//
// input channel: one message byte per transfer (data_byte, end_of_message),
// with in_valid and in_stall; a byte is taken when in_valid is high and
// in_stall low. output channel: one character per transfer (out_char,
// out_final) with out_valid and out_stall; out_final marks the last
// character of a message. configuration: cfg_valid / cfg_ready write of
// cfg_data to register cfg_index (0 alphabet, 1 padding); cfg_ready is
// always high. write only while no message is in flight.
// the front end gathers bytes and pushes one job per group into a four
// entry queue; the back end pops a job and then sends one character per
// cycle while out_stall is low, and pops no new job until the last
// character of the current one is sent. a padded group with %3d sends
// three characters for each pad.
// a stalled receiver holds the output register; the queue fills and then
// in_stall rises. reset clears the group, queue, sequencer and registers.
module base64_stream_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_final,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data
);

  b64se_pkg::cfg_t cfg;
  b64se_pkg::job_t push_job;
  b64se_pkg::job_t head_job;
  logic            push;
  logic            full;
  logic            pop;
  logic            head_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        b64se_pkg::REG_ALPHABET: cfg.alphabet <= cfg_data[0];
        b64se_pkg::REG_PAD:      cfg.pad      <= cfg_data;
        default: ;
      endcase
    end
  end

  b64se_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .q_full         (full),
    .q_push         (push),
    .q_job          (push_job)
  );

  b64se_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64se_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (head_valid),
    .q_job     (head_job),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_final (out_final)
  );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the base64 stream encoder: directed and random messages, scoreboard
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 10;
  localparam logic [1:0] PAD_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } msg_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_message = 1'b0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [1:0] cfg_data = 2'd0;
  wire        in_stall;
  wire        out_valid;
  wire  [7:0] out_char;
  wire        out_final;
  wire        cfg_ready;

  msg_byte_t  pending_bytes[$];
  enc_char_t  expected_chars[$];

  logic        enc_alphabet = 1'b0;
  logic [1:0]  enc_pad = b64se_pkg::PAD_EQ;
  logic [15:0] enc_held = 16'h0000;
  logic [1:0]  enc_phase = 2'd0;

  int  mismatches = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_left = 0;
  int  hold_requests = 0;
  int  holds_served = 0;
  bit  quiet = 1'b0;

  base64_stream_encoder_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_final      (out_final),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] b64_symbol(input logic [5:0] s);
    if (s < 6'd26) begin
      return b64se_pkg::CHAR_UPPER_A + {2'b00, s};
    end else if (s < 6'd52) begin
      return b64se_pkg::CHAR_LOWER_A + ({2'b00, s} - 8'd26);
    end else if (s < 6'd62) begin
      return b64se_pkg::CHAR_ZERO + ({2'b00, s} - 8'd52);
    end else if (s == 6'd62) begin
      return enc_alphabet ? b64se_pkg::CHAR_MINUS : b64se_pkg::CHAR_PLUS;
    end
    return enc_alphabet ? b64se_pkg::CHAR_UNDER : b64se_pkg::CHAR_SLASH;
  endfunction

  // advances the group state by one byte and queues the characters it releases
  task automatic encode_byte(input logic [7:0] b, input logic eom);
    logic [7:0]  chars[$];
    logic [23:0] grp;
    int          ndata;
    int          npad;
    enc_char_t   item;
    ndata = 0;
    npad = 0;
    case (enc_phase)
      2'd0: begin
        grp = {b, 16'h0000};
        enc_held = {8'h00, b};
        enc_phase = 2'd1;
        if (eom) begin
          ndata = 2;
          npad = 2;
        end
      end
      2'd1: begin
        enc_held = {enc_held[7:0], b};
        grp = {enc_held, 8'h00};
        enc_phase = 2'd2;
        if (eom) begin
          ndata = 3;
          npad = 1;
        end
      end
      default: begin
        grp = {enc_held, b};
        ndata = 4;
        enc_held = 16'h0000;
        enc_phase = 2'd0;
      end
    endcase
    for (int i = 0; i < ndata; i++) begin
      chars.push_back(b64_symbol(grp[23 - 6 * i -: 6]));
    end
    for (int p = 0; p < npad; p++) begin
      if (enc_pad == b64se_pkg::PAD_EQ) begin
        chars.push_back(b64se_pkg::CHAR_EQUALS);
      end else if (enc_pad == b64se_pkg::PAD_PCT) begin
        chars.push_back(b64se_pkg::CHAR_PERCENT);
        chars.push_back(b64se_pkg::CHAR_THREE);
        chars.push_back(b64se_pkg::CHAR_LOWER_D);
      end
    end
    if (eom) begin
      enc_held = 16'h0000;
      enc_phase = 2'd0;
    end
    for (int i = 0; i < chars.size(); i++) begin
      item.ch = chars[i];
      item.fin = eom && (i == chars.size() - 1);
      expected_chars.push_back(item);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch: %s, got %02h expected %02h", what, got, want);
    mismatches++;
  endtask

  // byte transfers
  always @(posedge clk) begin : driver
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        encode_byte(data_byte, end_of_message);
        void'(pending_bytes.pop_front());
        nv = 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 7);
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_bytes.size() > 0) begin
          data_byte <= pending_bytes[0].value;
          end_of_message <= pending_bytes[0].last;
          nv = 1'b1;
        end
      end
      in_valid <= nv;
    end
  end

  // character transfers
  always @(posedge clk) begin : monitor
    logic      ns;
    enc_char_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("character with nothing expected", out_char, 8'h00);
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) report_mismatch("out_char", out_char, want.ch);
          if (out_final !== want.fin) begin
            report_mismatch("out_final", {7'd0, out_final}, {7'd0, want.fin});
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ns = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        ns = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(0, 6);
        ns = 1'b1;
      end else begin
        ns = 1'b0;
      end
      out_stall <= ns;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] value, input logic last);
    msg_byte_t item;
    item.value = value;
    item.last = last;
    pending_bytes.push_back(item);
  endtask

  task automatic push_message(output int len);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || expected_chars.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == b64se_pkg::REG_ALPHABET) begin
      enc_alphabet = val[0];
    end else if (idx == b64se_pkg::REG_PAD) begin
      enc_pad = val;
    end
  endtask

  task automatic new_setting(input logic alphabet, input logic [1:0] pad);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(b64se_pkg::REG_ALPHABET, {1'b0, alphabet});
    write_reg(b64se_pkg::REG_PAD, pad);
  endtask

  initial begin : stimulus
    int n;
    int len;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: standard alphabet, '=' padding
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFB, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBE, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);

    new_setting(1'b1, b64se_pkg::PAD_PCT);
    push_byte(8'hFB, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hBF, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b1);

    new_setting(1'b0, b64se_pkg::PAD_NONE);
    push_byte(8'hAB, 1'b1);
    push_byte(8'hCD, 1'b0);
    push_byte(8'hEF, 1'b1);

    // unused pad code behaves as no padding
    new_setting(1'b1, PAD_SPARE);
    push_byte(8'h80, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);

    for (int k = 0; k < 8; k++) begin
      new_setting(k[0], 2'((k >> 1) & 3));
      if (k == 7) quiet = 1'b1;
      n = 0;
      while (n < ((k == 2) ? 20 : 8)) begin
        push_message(len);
        n += len;
      end
      if (k == 2) hold_requests++;
    end

    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
